// File: hw/rtl/nfbs_pkg.sv
package nfbs_pkg;

  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned TIMER_W     = 16;
  localparam int unsigned CMD_CNT_W   = 3;
  localparam int unsigned CMD_WORD_W  = 40;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam int unsigned ADDR_BITS_DEF = 24;
  localparam int unsigned MAX_CMDS_DEF  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORD_MODE = 3'd0,
    CFG_OE_TIME   = 3'd1,
    CFG_BP_TIME   = 3'd2,
    CFG_CMD_COUNT = 3'd3,
    CFG_CMD_WORD0 = 3'd4,
    CFG_CMD_WORD1 = 3'd5,
    CFG_CMD_WORD2 = 3'd6,
    CFG_CMD_WORD3 = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RD_OE     = 4'd1,
    PH_RD_GAP    = 4'd2,
    PH_WR_WAIT   = 4'd3,
    PH_WR_STROBE = 4'd4,
    PH_WR_GAP    = 4'd5
  } phase_t;

  typedef struct packed {
    logic                 word_mode;
    logic [TIMER_W-1:0]   oe_time;
    logic [TIMER_W-1:0]   bp_time;
    logic [CMD_CNT_W-1:0] cmd_count;
  } nfbs_cfg_t;

  typedef struct packed {
    logic              request_valid;
    logic              operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic              busy_in;
    logic [DATA_W-1:0] data_in;
  } nfbs_item_t;

  typedef struct packed {
    logic              ready_res;
    logic [ADDR_W-1:0] address_out;
    logic [DATA_W-1:0] data_out;
    logic              data_drive;
    logic              oe_active;
    logic              we_active;
    logic              read_valid;
    logic [DATA_W-1:0] read_word;
    logic              write_done;
  } nfbs_res_t;

  function automatic logic [DATA_W-1:0] data_mask(input logic word_mode,
                                                  input logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] m;
    m = word_mode ? {DATA_W{1'b1}} : {{(DATA_W-BYTE_BITS){1'b0}}, {BYTE_BITS{1'b1}}};
    return d & m;
  endfunction

endpackage

// File: hw/rtl/nfbs_cfg_regs.sv
module nfbs_cfg_regs #(
  parameter int unsigned CMD_DEPTH = 4
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         wr_en,
  input  logic [nfbs_pkg::CFG_IDX_W-1:0]               wr_index,
  input  logic [nfbs_pkg::CMD_WORD_W-1:0]              wr_data,
  output nfbs_pkg::nfbs_cfg_t                          cfg,
  output logic [CMD_DEPTH-1:0][nfbs_pkg::CMD_WORD_W-1:0] cmd_words
);
  import nfbs_pkg::*;

  localparam int unsigned SLOT_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

  nfbs_cfg_t                             cfg_r;
  logic [CMD_DEPTH-1:0][CMD_WORD_W-1:0]  cmd_r;
  logic [1:0]                            slot;
  logic                                  slot_ok;

  assign slot    = wr_index[1:0];
  assign slot_ok = ({1'b0, slot} < 3'(CMD_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
      cmd_r <= '0;
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_WORD_MODE: cfg_r.word_mode <= wr_data[0];
        CFG_OE_TIME:   cfg_r.oe_time   <= wr_data[TIMER_W-1:0];
        CFG_BP_TIME:   cfg_r.bp_time   <= wr_data[TIMER_W-1:0];
        CFG_CMD_COUNT: cfg_r.cmd_count <= wr_data[CMD_CNT_W-1:0];
        CFG_CMD_WORD0, CFG_CMD_WORD1, CFG_CMD_WORD2, CFG_CMD_WORD3: begin
          // writes to slots past the command depth are dropped
          if (slot_ok) begin
            cmd_r[SLOT_W'(slot)] <= wr_data;
          end
        end
        default: ;
      endcase
    end
  end

  assign cfg       = cfg_r;
  assign cmd_words = cmd_r;

endmodule

// File: hw/rtl/nfbs_seq.sv
module nfbs_seq #(
  parameter int unsigned ADDR_BITS = nfbs_pkg::ADDR_BITS_DEF,
  parameter int unsigned MAX_CMDS  = nfbs_pkg::MAX_CMDS_DEF,
  parameter int unsigned CMD_DEPTH = 4
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           step_en,
  input  nfbs_pkg::nfbs_item_t                           item,
  input  nfbs_pkg::nfbs_cfg_t                            cfg,
  input  logic [CMD_DEPTH-1:0][nfbs_pkg::CMD_WORD_W-1:0] cmd_words,
  output nfbs_pkg::nfbs_res_t                            res
);
  import nfbs_pkg::*;

  localparam int unsigned SLOT_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam logic [ADDR_W-1:0] ADDR_KEEP =
    (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  phase_t               phase_r, phase_nxt;
  logic [TIMER_W-1:0]   timer_r, timer_nxt;
  logic [CMD_CNT_W-1:0] cmd_idx_r, cmd_idx_nxt;
  logic [ADDR_W-1:0]    held_addr_r, held_addr_nxt;
  logic [DATA_W-1:0]    held_data_r, held_data_nxt;
  logic [ADDR_W-1:0]    drv_addr_r, drv_addr_nxt;
  logic [DATA_W-1:0]    drv_data_r, drv_data_nxt;

  logic [CMD_CNT_W-1:0]  eff_cmds;
  logic                  more_cmds;
  logic [CMD_WORD_W-1:0] cur_cmd;
  logic                  timer_zero;
  logic                  oe, we, rvalid, wdone;

  assign eff_cmds   = (cfg.cmd_count > CMD_CNT_W'(MAX_CMDS)) ?
                      CMD_CNT_W'(MAX_CMDS) : cfg.cmd_count;
  assign more_cmds  = cmd_idx_r < eff_cmds;
  assign cur_cmd    = cmd_words[cmd_idx_r[SLOT_W-1:0]];
  assign timer_zero = (timer_r == '0);

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    timer_nxt     = timer_r;
    cmd_idx_nxt   = cmd_idx_r;
    held_addr_nxt = held_addr_r;
    held_data_nxt = held_data_r;
    drv_addr_nxt  = drv_addr_r;
    drv_data_nxt  = drv_data_r;
    case (phase_r)
      PH_RD_OE: begin
        if (!timer_zero) begin
          timer_nxt = timer_r - 1'b1;
        end else begin
          phase_nxt = PH_RD_GAP;
          timer_nxt = cfg.oe_time;
        end
      end
      PH_RD_GAP: begin
        if (!timer_zero) timer_nxt = timer_r - 1'b1;
        else phase_nxt = PH_IDLE;
      end
      PH_WR_WAIT: begin
        if (!item.busy_in) begin
          if (more_cmds) begin
            drv_addr_nxt = cur_cmd[CMD_WORD_W-1:DATA_W] & ADDR_KEEP;
            drv_data_nxt = cur_cmd[DATA_W-1:0];
          end else begin
            drv_addr_nxt = held_addr_r;
            drv_data_nxt = held_data_r;
          end
          phase_nxt = PH_WR_STROBE;
          timer_nxt = cfg.oe_time;
        end
      end
      PH_WR_STROBE: begin
        if (!timer_zero) begin
          timer_nxt = timer_r - 1'b1;
        end else begin
          phase_nxt = PH_WR_GAP;
          timer_nxt = cfg.bp_time;
        end
      end
      PH_WR_GAP: begin
        if (!timer_zero) begin
          timer_nxt = timer_r - 1'b1;
        end else if (more_cmds) begin
          cmd_idx_nxt = cmd_idx_r + 1'b1;
          phase_nxt   = PH_WR_WAIT;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (item.request_valid) begin
          if (!item.operation) begin
            drv_addr_nxt = item.address & ADDR_KEEP;
            phase_nxt    = PH_RD_OE;
            timer_nxt    = cfg.oe_time;
          end else begin
            held_addr_nxt = item.address & ADDR_KEEP;
            held_data_nxt = data_mask(cfg.word_mode, item.write_data);
            cmd_idx_nxt   = '0;
            phase_nxt     = PH_WR_WAIT;
          end
        end
      end
    endcase
  end

  // strobes and status
  always_comb begin
    oe     = 1'b0;
    we     = 1'b0;
    rvalid = 1'b0;
    wdone  = 1'b0;
    case (phase_r)
      PH_RD_OE: begin
        oe     = !timer_zero;
        rvalid = timer_zero;
      end
      PH_RD_GAP: ;
      PH_WR_WAIT:   we = !item.busy_in;
      PH_WR_STROBE: we = !timer_zero;
      PH_WR_GAP:    wdone = timer_zero && !more_cmds;
      default:      oe = item.request_valid && !item.operation;
    endcase
    res.ready_res   = (phase_nxt == PH_IDLE);
    res.address_out = drv_addr_nxt;
    res.data_out    = data_mask(cfg.word_mode, drv_data_nxt);
    res.data_drive  = (phase_nxt == PH_WR_WAIT) || (phase_nxt == PH_WR_STROBE) ||
                      (phase_nxt == PH_WR_GAP) || wdone;
    res.oe_active   = oe;
    res.we_active   = we;
    res.read_valid  = rvalid;
    res.read_word   = rvalid ? data_mask(cfg.word_mode, item.data_in) : '0;
    res.write_done  = wdone;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      timer_r     <= '0;
      cmd_idx_r   <= '0;
      held_addr_r <= '0;
      held_data_r <= '0;
      drv_addr_r  <= '0;
      drv_data_r  <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      cmd_idx_r   <= cmd_idx_nxt;
      held_addr_r <= held_addr_nxt;
      held_data_r <= held_data_nxt;
      drv_addr_r  <= drv_addr_nxt;
      drv_data_r  <= drv_data_nxt;
    end
  end

  a_strobe_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(oe && we))
    else $error("oe and we asserted together");

  a_cmd_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_idx_r <= CMD_CNT_W'(MAX_CMDS))
    else $error("command index past command limit");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && wdone) |=> (phase_r == PH_IDLE))
    else $error("write done without return to idle");

  a_hold_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(phase_r) && $stable(timer_r))
    else $error("sequencer state moved without an item");

endmodule

// File: hw/rtl/nor_flash_bus_sequencer_core.sv
// Channel | Dir | Handshake           | Payload
// in_     | in  | in_tvalid/in_tready | in_tdata: request fields and pin levels, in_tuser: op
// out_    | out | out_tvalid/out_tready | out_tdata: pin levels and status of one tick
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item is one bus tick; the block takes one item per cycle while out_tready does not stall it,
// through two register stages (input register, then sequencer step into the output register): a
// result shows on out_tdata once its item has moved from the input to the output register.
// rst_n is synchronous: it clears the valid flags of both stages, the sequencer state and
// the configuration registers; the item and result data registers are not reset.
// A stall on out_tready holds the output register, the sequencer and the input register;
// the input stage keeps taking items until it holds one that cannot move on.
// cfg_ready is always high; a write lands in the next cycle.
module nor_flash_bus_sequencer_core #(
  parameter int unsigned ADDR_BITS = nfbs_pkg::ADDR_BITS_DEF,
  parameter int unsigned MAX_CMDS  = nfbs_pkg::MAX_CMDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] request_valid, [24:1] address, [40:25] write_data, [41] busy_in,
  // [57:42] data_in, rest zero
  input  logic [nfbs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] operation
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] ready_res, [24:1] address_out, [40:25] data_out, [41] data_drive,
  // [42] oe_active, [43] we_active, [44] read_valid, [60:45] read_word,
  // [61] write_done, rest zero
  output logic [nfbs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nfbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nfbs_pkg::CMD_WORD_W-1:0]     cfg_data
);
  import nfbs_pkg::*;

  localparam int unsigned CMD_SLOT_W = (MAX_CMDS > 1) ? $clog2(MAX_CMDS) : 1;
  localparam int unsigned CMD_DEPTH  = 2 ** CMD_SLOT_W;

  nfbs_cfg_t                            cfg;
  logic [CMD_DEPTH-1:0][CMD_WORD_W-1:0] cmd_words;

  logic       in_valid_r;
  nfbs_item_t in_item_r, in_item;
  logic       out_valid_r;
  nfbs_res_t  out_res_r, step_res;
  logic       advance;
  logic       step_en;

  assign advance   = !out_valid_r || out_tready;
  assign step_en   = advance && in_valid_r;
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign in_item.request_valid = in_tdata[0];
  assign in_item.operation     = in_tuser;
  assign in_item.address       = in_tdata[24:1];
  assign in_item.write_data    = in_tdata[40:25];
  assign in_item.busy_in       = in_tdata[41];
  assign in_item.data_in       = in_tdata[57:42];

  nfbs_cfg_regs #(
    .CMD_DEPTH (CMD_DEPTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .cfg       (cfg),
    .cmd_words (cmd_words)
  );

  nfbs_seq #(
    .ADDR_BITS (ADDR_BITS),
    .MAX_CMDS  (MAX_CMDS),
    .CMD_DEPTH (CMD_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (in_item_r),
    .cfg       (cfg),
    .cmd_words (cmd_words),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       out_res_r.write_done,
                       out_res_r.read_word,
                       out_res_r.read_valid,
                       out_res_r.we_active,
                       out_res_r.oe_active,
                       out_res_r.data_drive,
                       out_res_r.data_out,
                       out_res_r.address_out,
                       out_res_r.ready_res};

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r && $stable(in_item_r))
    else $error("input item dropped during stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r && $stable(out_res_r))
    else $error("result changed during stall");

  a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_valid_r)
    else $error("stepped item produced no result");

endmodule

// File: test/nor_flash_bus_sequencer_core_tb.sv
`timescale 1ns / 1ps

module nor_flash_bus_sequencer_core_tb;
  import nfbs_pkg::*;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_PROGRAM = 1'b1;
  localparam logic [2:0] UNLOCK_MAX = 3'(MAX_CMDS_DEF);
  localparam int RAND_TICKS = 150;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // [0] request_valid, [24:1] address, [40:25] write_data, [41] busy_in,
  // [57:42] data_in, rest zero
  logic [IN_TDATA_W-1:0] in_tdata;
  // [0] operation
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  // [0] ready_res, [24:1] address_out, [40:25] data_out, [41] data_drive,
  // [42] oe_active, [43] we_active, [44] read_valid, [60:45] read_word,
  // [61] write_done, rest zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CMD_WORD_W-1:0] cfg_data;

  nor_flash_bus_sequencer_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // register copy
  logic wide_bus;
  logic [TIMER_W-1:0] oe_ticks;
  logic [TIMER_W-1:0] bp_ticks;
  logic [CMD_CNT_W-1:0] unlock_cnt;
  logic [CMD_WORD_W-1:0] unlock_word [4];

  // sequencer copy
  phase_t bus_phase;
  logic [TIMER_W-1:0] tick_left;
  logic [CMD_CNT_W-1:0] unlock_idx;
  logic [ADDR_W-1:0] held_addr;
  logic [ADDR_W-1:0] drv_addr;
  logic [DATA_W-1:0] held_word;
  logic [DATA_W-1:0] drv_word;

  nfbs_res_t pin_q[$];
  logic [CMD_WORD_W-1:0] reg_plan [8];
  int gap_pct;
  int stall_pct;
  int errors;
  int checked;
  int ticks_sent;
  int reads_taken;
  int programs_taken;

  typedef struct {
    nfbs_item_t it;
    bit typed;
    nfbs_res_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("nor_flash_bus_sequencer_core_tb NOT OK");
    $finish;
  end

  function automatic logic [DATA_W-1:0] bus_lane(logic [DATA_W-1:0] d);
    return wide_bus ? d : {8'h00, d[7:0]};
  endfunction

  function automatic logic [CMD_CNT_W-1:0] unlock_total();
    return (unlock_cnt > UNLOCK_MAX) ? UNLOCK_MAX : unlock_cnt;
  endfunction

  function automatic void take_reg(cfg_idx_t k, logic [CMD_WORD_W-1:0] v);
    case (k)
      CFG_WORD_MODE: wide_bus = v[0];
      CFG_OE_TIME:   oe_ticks = v[TIMER_W-1:0];
      CFG_BP_TIME:   bp_ticks = v[TIMER_W-1:0];
      CFG_CMD_COUNT: unlock_cnt = v[CMD_CNT_W-1:0];
      CFG_CMD_WORD0: unlock_word[0] = v;
      CFG_CMD_WORD1: unlock_word[1] = v;
      CFG_CMD_WORD2: unlock_word[2] = v;
      CFG_CMD_WORD3: unlock_word[3] = v;
      default: ;
    endcase
  endfunction

  // advance the sequencer copy by one bus tick
  function automatic nfbs_res_t step_bus(nfbs_item_t it);
    nfbs_res_t r;
    logic [CMD_WORD_W-1:0] w;
    logic done;
    r = '0;
    done = 1'b0;
    case (bus_phase)
      PH_RD_OE: begin
        if (tick_left != 0) begin
          tick_left = tick_left - 1'b1;
          r.oe_active = 1'b1;
        end else begin
          r.read_valid = 1'b1;
          r.read_word = bus_lane(it.data_in);
          bus_phase = PH_RD_GAP;
          tick_left = oe_ticks;
        end
      end
      PH_RD_GAP: begin
        if (tick_left != 0) tick_left = tick_left - 1'b1;
        else bus_phase = PH_IDLE;
      end
      PH_WR_WAIT: begin
        if (!it.busy_in) begin
          if (unlock_idx < unlock_total()) begin
            w = unlock_word[unlock_idx[1:0]];
            drv_addr = w[39:16];
            drv_word = w[15:0];
          end else begin
            drv_addr = held_addr;
            drv_word = held_word;
          end
          bus_phase = PH_WR_STROBE;
          tick_left = oe_ticks;
          r.we_active = 1'b1;
        end
      end
      PH_WR_STROBE: begin
        if (tick_left != 0) begin
          tick_left = tick_left - 1'b1;
          r.we_active = 1'b1;
        end else begin
          bus_phase = PH_WR_GAP;
          tick_left = bp_ticks;
        end
      end
      PH_WR_GAP: begin
        if (tick_left != 0) begin
          tick_left = tick_left - 1'b1;
        end else if (unlock_idx < unlock_total()) begin
          unlock_idx = unlock_idx + 1'b1;
          bus_phase = PH_WR_WAIT;
        end else begin
          done = 1'b1;
          bus_phase = PH_IDLE;
        end
      end
      default: begin
        bus_phase = PH_IDLE;
        if (it.request_valid) begin
          if (it.operation == OP_READ) begin
            drv_addr = it.address;
            bus_phase = PH_RD_OE;
            tick_left = oe_ticks;
            r.oe_active = 1'b1;
          end else begin
            held_addr = it.address;
            held_word = bus_lane(it.write_data);
            unlock_idx = '0;
            bus_phase = PH_WR_WAIT;
          end
        end
      end
    endcase
    r.ready_res = (bus_phase == PH_IDLE);
    r.address_out = drv_addr;
    r.data_out = bus_lane(drv_word);
    r.data_drive = done || bus_phase == PH_WR_WAIT || bus_phase == PH_WR_STROBE ||
                   bus_phase == PH_WR_GAP;
    r.write_done = done;
    return r;
  endfunction

  function automatic nfbs_item_t tick(logic req, logic op, logic [ADDR_W-1:0] a,
                                      logic [DATA_W-1:0] wd, logic busy,
                                      logic [DATA_W-1:0] din);
    nfbs_item_t t;
    t.request_valid = req;
    t.operation = op;
    t.address = a;
    t.write_data = wd;
    t.busy_in = busy;
    t.data_in = din;
    return t;
  endfunction

  function automatic nfbs_res_t pins(logic rdy, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
                                     logic drv, logic oe, logic we, logic rv,
                                     logic [DATA_W-1:0] rw, logic wd);
    nfbs_res_t r;
    r.ready_res = rdy;
    r.address_out = a;
    r.data_out = d;
    r.data_drive = drv;
    r.oe_active = oe;
    r.we_active = we;
    r.read_valid = rv;
    r.read_word = rw;
    r.write_done = wd;
    return r;
  endfunction

  function automatic void add_row(nfbs_item_t it, bit typed, nfbs_res_t want);
    dir_row_t row;
    row.it = it;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return ADDR_W'($urandom);
    endcase
  endfunction

  // mostly requests while idle, busy now and then while waiting to program
  function automatic nfbs_item_t rand_tick();
    nfbs_item_t t;
    t = tick($urandom_range(4) == 0, 1'($urandom_range(1)), rand_addr(), DATA_W'($urandom),
             1'($urandom_range(1)), DATA_W'($urandom));
    if (bus_phase == PH_IDLE) t.request_valid = ($urandom_range(9) < 7);
    if (bus_phase == PH_WR_WAIT) t.busy_in = ($urandom_range(9) < 3);
    return t;
  endfunction

  function automatic nfbs_item_t filler();
    return tick(1'b0, 1'($urandom_range(1)), rand_addr(), DATA_W'($urandom), 1'b0,
                DATA_W'($urandom));
  endfunction

  function automatic nfbs_res_t from_bus(logic [OUT_TDATA_W-1:0] d);
    nfbs_res_t r;
    r.ready_res = d[0];
    r.address_out = d[24:1];
    r.data_out = d[40:25];
    r.data_drive = d[41];
    r.oe_active = d[42];
    r.we_active = d[43];
    r.read_valid = d[44];
    r.read_word = d[60:45];
    r.write_done = d[61];
    return r;
  endfunction

  task automatic flag(string what, logic [31:0] got_v, logic [31:0] want_v);
    if (errors < 40)
      $display("%0t: result %0d: %s got %h want %h", $time, checked, what, got_v, want_v);
    errors++;
  endtask

  task automatic check_tick(nfbs_res_t got, nfbs_res_t want);
    if (got.ready_res !== want.ready_res)
      flag("ready_res", 32'(got.ready_res), 32'(want.ready_res));
    if (got.address_out !== want.address_out)
      flag("address_out", 32'(got.address_out), 32'(want.address_out));
    if (got.data_out !== want.data_out)
      flag("data_out", 32'(got.data_out), 32'(want.data_out));
    if (got.data_drive !== want.data_drive)
      flag("data_drive", 32'(got.data_drive), 32'(want.data_drive));
    if (got.oe_active !== want.oe_active)
      flag("oe_active", 32'(got.oe_active), 32'(want.oe_active));
    if (got.we_active !== want.we_active)
      flag("we_active", 32'(got.we_active), 32'(want.we_active));
    if (got.read_valid !== want.read_valid)
      flag("read_valid", 32'(got.read_valid), 32'(want.read_valid));
    if (got.read_word !== want.read_word)
      flag("read_word", 32'(got.read_word), 32'(want.read_word));
    if (got.write_done !== want.write_done)
      flag("write_done", 32'(got.write_done), 32'(want.write_done));
  endtask

  always @(posedge clk) begin : sink
    nfbs_res_t got;
    nfbs_res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = from_bus(out_tdata);
        if (pin_q.size() == 0) begin
          flag("item with nothing expected", 32'(got.ready_res), 32'd0);
        end else begin
          want = pin_q.pop_front();
          check_tick(got, want);
        end
        checked++;
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // hold valid high across back-to-back items; lower it only on a gap
  task automatic send_tick(nfbs_item_t it, bit typed, nfbs_res_t want);
    nfbs_res_t pred;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, it.data_in, it.busy_in, it.write_data, it.address, it.request_valid};
    in_tuser <= it.operation;
    do @(posedge clk); while (!in_tready);
    if (bus_phase == PH_IDLE && it.request_valid) begin
      if (it.operation == OP_READ) reads_taken++;
      else programs_taken++;
    end
    pred = step_bus(it);
    pin_q.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (pin_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // run the sequencer back to idle, then let the pipeline empty
  task automatic drain();
    while (bus_phase != PH_IDLE) send_tick(filler(), 1'b0, '0);
    quiesce();
  endtask

  task automatic set_plan(logic wm, logic [TIMER_W-1:0] oe, logic [TIMER_W-1:0] bp,
                          logic [CMD_CNT_W-1:0] cnt);
    reg_plan[CFG_WORD_MODE] = CMD_WORD_W'(wm);
    reg_plan[CFG_OE_TIME] = CMD_WORD_W'(oe);
    reg_plan[CFG_BP_TIME] = CMD_WORD_W'(bp);
    reg_plan[CFG_CMD_COUNT] = CMD_WORD_W'(cnt);
    reg_plan[CFG_CMD_WORD0] = {8'($urandom), $urandom};
    reg_plan[CFG_CMD_WORD1] = {8'($urandom), $urandom};
    reg_plan[CFG_CMD_WORD2] = {8'($urandom), $urandom};
    reg_plan[CFG_CMD_WORD3] = {8'($urandom), $urandom};
  endtask

  task automatic load_regs();
    cfg_idx_t k;
    k = k.first();
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= k;
      cfg_data <= reg_plan[int'(k)];
      do @(posedge clk); while (!cfg_ready);
      take_reg(k, reg_plan[int'(k)]);
      k = k.next();
    end while (k != k.first());
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n) send_tick(rand_tick(), 1'b0, '0);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    wide_bus = 1'b0;
    oe_ticks = '0;
    bp_ticks = '0;
    unlock_cnt = '0;
    for (int i = 0; i < 4; i++) unlock_word[i] = '0;
    bus_phase = PH_IDLE;
    tick_left = '0;
    unlock_idx = '0;
    held_addr = '0;
    drv_addr = '0;
    held_word = '0;
    drv_word = '0;
    errors = 0;
    checked = 0;
    ticks_sent = 0;
    reads_taken = 0;
    programs_taken = 0;
    gap_pct = 8;
    stall_pct = 51;

    // byte bus, no stretch, no unlock cycles after reset
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 0, 16'hFFFF), 1,
            pins(1, 24'h000000, 16'h0000, 0, 0, 0, 0, 16'h0000, 0));
    add_row(tick(1, OP_READ, 24'hFFFFFF, 16'hFFFF, 1, 16'h0000), 1,
            pins(0, 24'hFFFFFF, 16'h0000, 0, 1, 0, 0, 16'h0000, 0));
    // request during a read is dropped; sample masked to the low byte
    add_row(tick(1, OP_PROGRAM, 24'h123456, 16'h1234, 0, 16'hFFFF), 1,
            pins(0, 24'hFFFFFF, 16'h0000, 0, 0, 0, 1, 16'h00FF, 0));
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 0, 16'hFFFF), 1,
            pins(1, 24'hFFFFFF, 16'h0000, 0, 0, 0, 0, 16'h0000, 0));
    // busy on the acceptance tick is not looked at
    add_row(tick(1, OP_PROGRAM, 24'h000000, 16'hFFFF, 1, 16'h0000), 1,
            pins(0, 24'hFFFFFF, 16'h0000, 1, 0, 0, 0, 16'h0000, 0));
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 1, 16'h0000), 1,
            pins(0, 24'hFFFFFF, 16'h0000, 1, 0, 0, 0, 16'h0000, 0));
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 0, 16'h0000), 1,
            pins(0, 24'h000000, 16'h00FF, 1, 0, 1, 0, 16'h0000, 0));
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 1, 16'h0000), 1,
            pins(0, 24'h000000, 16'h00FF, 1, 0, 0, 0, 16'h0000, 0));
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 0, 16'h0000), 1,
            pins(1, 24'h000000, 16'h00FF, 1, 0, 0, 0, 16'h0000, 1));
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 0, 16'h0000), 1,
            pins(1, 24'h000000, 16'h00FF, 0, 0, 0, 0, 16'h0000, 0));
    add_row(tick(1, OP_READ, 24'h555555, 16'hAAAA, 0, 16'h0000), 0, '0);
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 0, 16'hAAAA), 0, '0);
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 0, 16'h5555), 0, '0);
    add_row(tick(1, OP_PROGRAM, 24'hAAAAAA, 16'h5A5A, 0, 16'hFFFF), 0, '0);
    add_row(tick(1, OP_READ, 24'h5A5A5A, 16'h0000, 1, 16'h0000), 0, '0);
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 1, 16'h0000), 0, '0);
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 0, 16'h0000), 0, '0);
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 0, 16'h0000), 0, '0);
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 0, 16'h0000), 0, '0);
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 0, 16'h0000), 0, '0);
    add_row(tick(1, OP_READ, 24'h000001, 16'h0000, 0, 16'hFFFF), 0, '0);
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 0, 16'h0000), 0, '0);
    add_row(tick(0, OP_READ, 24'h000000, 16'h0000, 0, 16'h0000), 0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_tick(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    drain();

    // word bus, shortest timing, full unlock set with edge patterns
    set_plan(1'b1, 16'd0, 16'd0, 3'd4);
    reg_plan[CFG_CMD_WORD0] = '1;
    reg_plan[CFG_CMD_WORD1] = '0;
    reg_plan[CFG_CMD_WORD2] = 40'h55_5555_5555;
    reg_plan[CFG_CMD_WORD3] = 40'hAA_AAAA_AAAA;
    load_regs();
    run_random(RAND_TICKS);

    gap_pct = 51;
    stall_pct = 8;
    set_plan(1'b0, 16'd3, 16'd2, 3'd7);
    load_regs();
    run_random(RAND_TICKS);

    gap_pct = 0;
    stall_pct = 0;
    set_plan(1'b1, 16'd1, 16'd4, 3'd2);
    load_regs();
    run_random(RAND_TICKS);

    set_plan(1'b0, 16'd0, 16'd1, 3'd5);
    load_regs();
    run_random(RAND_TICKS);

    // long strobes and gaps: one read, one program
    set_plan(1'b1, 16'd16, 16'd16, 3'd0);
    load_regs();
    send_tick(tick(1, OP_READ, rand_addr(), DATA_W'($urandom), 0, DATA_W'($urandom)), 0, '0);
    drain();
    send_tick(tick(1, OP_PROGRAM, rand_addr(), DATA_W'($urandom), 0, DATA_W'($urandom)),
              0, '0);
    drain();

    in_tvalid <= 1'b0;
    while (pin_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("ran %0d bus ticks: %0d reads and %0d programs started, %0d items checked",
             ticks_sent, reads_taken, programs_taken, checked);
    $display("byte and word bus, timers 0 to 16, unlock counts 0 to 7; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("nor_flash_bus_sequencer_core_tb OK");
    end else begin
      $display("nor_flash_bus_sequencer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
